/* rtl/fotm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and reorder function of the first-owner triangle marker
package fotm_pkg;

	localparam int INDEX_COUNT_DEF = 65536;
	localparam int IDX_W           = 16;
	localparam int CNT_W           = 2;
	localparam int S_TDATA_W       = 48;
	localparam int M_TDATA_W       = 56;

	localparam logic MODE_VERTEX = 1'b0;
	localparam logic MODE_EDGE   = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] new_count;
		idx_t             out_c;
		idx_t             out_b;
		idx_t             out_a;
	} out_item_t;

	localparam int M_PAD_W = M_TDATA_W - $bits(out_item_t);

	function automatic out_item_t fotm_reorder(input logic mode, input logic [2:0] fr,
			input idx_t a, input idx_t b, input idx_t c);
		out_item_t        r;
		logic [CNT_W-1:0] cnt;
		cnt = CNT_W'(fr[0]) + CNT_W'(fr[1]) + CNT_W'(fr[2]);
		r.new_count = cnt;
		r.out_a = a;
		r.out_b = b;
		r.out_c = c;
		if (mode == MODE_VERTEX) begin
			if (cnt == 2'd1) begin
				priority if (fr[1]) begin
					r.out_a = b; r.out_b = c; r.out_c = a;
				end else if (fr[2]) begin
					r.out_a = c; r.out_b = a; r.out_c = b;
				end
			end else if (cnt == 2'd2) begin
				priority if (!fr[0]) begin
					r.out_a = b; r.out_b = c; r.out_c = a;
				end else if (!fr[1]) begin
					r.out_a = c; r.out_b = a; r.out_c = b;
				end
			end
		end else begin
			if (cnt == 2'd1) begin
				priority if (fr[1]) begin
					r.out_a = b; r.out_b = a;
				end else if (fr[2]) begin
					r.out_a = c; r.out_c = a;
				end
			end else if (cnt == 2'd2) begin
				priority if (!fr[0]) begin
					r.out_a = c; r.out_c = a;
				end else if (!fr[1]) begin
					r.out_b = c; r.out_c = b;
				end
			end
		end
		return r;
	endfunction

endpackage

/* rtl/first_owner_triangle_marker_unit.sv */
`timescale 1ns / 1ps
// top level of the first-owner triangle marker
//
// Takes one triangle (three element indices) per item and returns the number of indices not
// seen before in the current mesh, with the new ones moved to the front by rotation
// (order_mode 0) or one swap (order_mode 1). The visited bitmap lives in one memory of
// 32-bit rows (2-bit rows when INDEX_COUNT is below 64) with one read and one write port;
// an item goes through accept, index-to-slot reduction, then three row reads on the read
// port, each followed by its write-back on the write port, the last one waiting for a free
// output. After reset and after each item with tlast set, the block sweeps the memory one
// row per cycle and accepts no item; the memory has 2**($clog2(INDEX_COUNT) - 5) rows (2048
// at the default size), 2**($clog2(INDEX_COUNT) - 1) below 64. Indices at or above
// INDEX_COUNT share the entry of their value modulo INDEX_COUNT.
module first_owner_triangle_marker_unit import fotm_pkg::*; #(
	parameter int INDEX_COUNT = INDEX_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // idx_a, idx_b, idx_c
	input  logic                 s_tlast,   // last_face
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_a, out_b, out_c, new_count, zero pad
	input  logic                 cfg_wen,
	input  logic                 cfg_wdata  // order_mode
);

	localparam int SLOT_W = $clog2(INDEX_COUNT);
	localparam int BSEL_W = (INDEX_COUNT >= 64) ? 5 : 1;
	localparam int ROW_W  = 1 << BSEL_W;
	localparam int ROW_AW = SLOT_W - BSEL_W;
	localparam int ROWS   = 1 << ROW_AW;

	logic [2:0][SLOT_W-1:0] slots;
	logic                   map_ld;
	logic                   ram_wr_en, ram_rd_en;
	logic [ROW_AW-1:0]      ram_wr_addr, ram_rd_addr;
	logic [ROW_W-1:0]       ram_wr_data, ram_rd_data;

	assign map_ld = s_tvalid & s_tready;

	generate
		for (genvar k = 0; k < 3; k++) begin : g_lane
			fotm_slot_map #(
				.INDEX_COUNT(INDEX_COUNT)
			) u_slot_map (
				.clk   (clk),
				.ld    (map_ld),
				.idx_in(s_tdata[k*IDX_W +: IDX_W]),
				.slot  (slots[k])
			);
		end
	endgenerate

	fotm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	fotm_ctrl #(
		.INDEX_COUNT(INDEX_COUNT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.slots      (slots),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.ram_rd_en  (ram_rd_en),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data)
	);

endmodule

/* rtl/fotm_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module fotm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/fotm_slot_map.sv */
`timescale 1ns / 1ps
// two-stage reduction of an element index to its bitmap slot
module fotm_slot_map import fotm_pkg::*; #(
	parameter int INDEX_COUNT = INDEX_COUNT_DEF,
	localparam int SLOT_W = $clog2(INDEX_COUNT)
) (
	input  logic              clk,
	input  logic              ld,
	input  idx_t              idx_in,
	output logic [SLOT_W-1:0] slot
);

	idx_t              idx_s1;
	logic [SLOT_W-1:0] slot_s2;

	generate
		if (INDEX_COUNT < (1 << IDX_W)) begin : g_mod
			localparam longint unsigned RECIP_L =
				((64'd1 << 32) + longint'(INDEX_COUNT) - 64'd1) / longint'(INDEX_COUNT);
			localparam logic [31:0] RECIP = 32'(RECIP_L);
			localparam idx_t        N16   = IDX_W'(INDEX_COUNT);

			logic [47:0] prod;
			idx_t        q_s1;
			logic [31:0] qn;
			idx_t        rem;

			assign prod = idx_in * RECIP;
			assign qn   = q_s1 * N16;
			assign rem  = idx_s1 - qn[IDX_W-1:0];

			always_ff @(posedge clk) begin
				if (ld) begin
					q_s1   <= prod[47:32];
					idx_s1 <= idx_in;
				end
				slot_s2 <= rem[SLOT_W-1:0];
			end
		end else begin : g_direct
			always_ff @(posedge clk) begin
				if (ld) begin
					idx_s1 <= idx_in;
				end
				slot_s2 <= SLOT_W'(idx_s1);
			end
		end
	endgenerate

	assign slot = slot_s2;

endmodule

/* rtl/fotm_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: bitmap read-modify-write, fresh tracking, reorder, clear sweep, output register
module fotm_ctrl import fotm_pkg::*; #(
	parameter int INDEX_COUNT = INDEX_COUNT_DEF,
	localparam int SLOT_W = $clog2(INDEX_COUNT),
	localparam int BSEL_W = (INDEX_COUNT >= 64) ? 5 : 1,
	localparam int ROW_W  = 1 << BSEL_W,
	localparam int ROW_AW = SLOT_W - BSEL_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [S_TDATA_W-1:0]       s_tdata,
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	input  logic                       cfg_wen,
	input  logic                       cfg_wdata,
	input  logic [2:0][SLOT_W-1:0]     slots,
	output logic                       ram_wr_en,
	output logic [ROW_AW-1:0]          ram_wr_addr,
	output logic [ROW_W-1:0]           ram_wr_data,
	output logic                       ram_rd_en,
	output logic [ROW_AW-1:0]          ram_rd_addr,
	input  logic [ROW_W-1:0]           ram_rd_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MAP   = 7'b0000010,
		ST_RD0   = 7'b0000100,
		ST_RD1   = 7'b0001000,
		ST_RD2   = 7'b0010000,
		ST_WR2   = 7'b0100000,
		ST_CLEAR = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [2:0][IDX_W-1:0] idx_q;
	logic                  last_q;
	logic [1:0]            fresh_q;
	logic                  mode_q;
	logic [ROW_AW-1:0]     clr_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [ROW_AW-1:0] row_a, row_b, row_c;
	logic [BSEL_W-1:0] bit_a, bit_b, bit_c;
	logic [ROW_W-1:0]  mask_a, mask_b, mask_c;
	logic              f_a, f_b, f_c;
	logic              accept, out_free;
	out_item_t         res;

	assign row_a = slots[0][SLOT_W-1:BSEL_W];
	assign row_b = slots[1][SLOT_W-1:BSEL_W];
	assign row_c = slots[2][SLOT_W-1:BSEL_W];
	assign bit_a = slots[0][BSEL_W-1:0];
	assign bit_b = slots[1][BSEL_W-1:0];
	assign bit_c = slots[2][BSEL_W-1:0];
	assign mask_a = {{(ROW_W-1){1'b0}}, 1'b1} << bit_a;
	assign mask_b = {{(ROW_W-1){1'b0}}, 1'b1} << bit_b;
	assign mask_c = {{(ROW_W-1){1'b0}}, 1'b1} << bit_c;

	// earlier slots of the same triangle count as already marked
	assign f_a = !ram_rd_data[bit_a];
	assign f_b = !ram_rd_data[bit_b] && (slots[1] != slots[0]);
	assign f_c = !ram_rd_data[bit_c] && (slots[2] != slots[0]) && (slots[2] != slots[1]);

	assign res = fotm_reorder(mode_q, {f_c, fresh_q[1], fresh_q[0]},
		idx_q[0], idx_q[1], idx_q[2]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_q};

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = row_a;
		ram_wr_en   = 1'b0;
		ram_wr_addr = row_a;
		ram_wr_data = '0;
		unique case (state_q)
			ST_RD0: begin
				ram_rd_en = 1'b1;
			end
			ST_RD1: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = row_b;
				ram_wr_en   = 1'b1;
				ram_wr_data = ram_rd_data | mask_a;
			end
			ST_RD2: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = row_c;
				ram_wr_en   = 1'b1;
				ram_wr_addr = row_b;
				ram_wr_data = ram_rd_data | mask_b | ((row_a == row_b) ? mask_a : '0);
			end
			ST_WR2: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = row_c;
				ram_wr_data = ram_rd_data | mask_c | ((row_a == row_c) ? mask_a : '0)
					| ((row_b == row_c) ? mask_b : '0);
			end
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_VERTEX;
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
			if (state_q == ST_WR2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					state_q <= ST_RD0;
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					if (out_free) begin
						clr_q   <= '0;
						state_q <= last_q ? ST_CLEAR : ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= s_tdata;
			last_q <= s_tlast;
		end
		if (state_q == ST_RD1) begin
			fresh_q[0] <= f_a;
		end
		if (state_q == ST_RD2) begin
			fresh_q[1] <= f_b;
		end
		if (state_q == ST_WR2 && out_free) begin
			out_q <= res;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 (state_q == ST_WR2))
		else $error("item did not reach final write on schedule");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_WR2)
		else $error("result shown without finishing an item");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR2 && out_free && last_q) |=> (state_q == ST_CLEAR && clr_q == '0))
		else $error("last face did not start a clear sweep");

endmodule

/* test/first_owner_triangle_marker_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the first-owner triangle marker: directed meshes, random meshes, idling phases
module first_owner_triangle_marker_unit_test;
	import fotm_pkg::*;

	localparam int MAP_SIZE   = INDEX_COUNT_DEF;
	localparam int PRINT_MAX  = 40;
	localparam int PHASE_ITEMS = 195;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_wen = 1'b0;
	logic                 cfg_wdata = MODE_VERTEX;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_cycles = 0;
	int tx_pct_by_phase [4] = '{0, 73, 0, 38};
	int rx_pct_by_phase [4] = '{0, 0, 73, 38};

	class triangle_scoreboard;
		bit        seen [MAP_SIZE];
		logic      mode;
		out_item_t expected_q [$];
		int        errors;

		function new();
			clear_seen();
			mode = MODE_VERTEX;
			errors = 0;
		endfunction

		function void clear_seen();
			foreach (seen[i])
				seen[i] = 1'b0;
		endfunction

		// claim the indices in slot order and build the reordered result
		function void note_triangle(idx_t a, idx_t b, idx_t c, logic last);
			idx_t       v [3];
			logic [2:0] fresh;
			out_item_t  e;
			int         slot;
			v[0] = a;
			v[1] = b;
			v[2] = c;
			e.new_count = '0;
			for (int k = 0; k < 3; k++) begin
				slot = int'(v[k]) % MAP_SIZE;
				fresh[k] = !seen[slot];
				if (fresh[k]) begin
					seen[slot] = 1'b1;
					e.new_count = e.new_count + 1'b1;
				end
			end
			e.out_a = a;
			e.out_b = b;
			e.out_c = c;
			if (mode == MODE_VERTEX) begin
				if ((e.new_count == 2'd1 && fresh[1]) || (e.new_count == 2'd2 && !fresh[0])) begin
					e.out_a = b; e.out_b = c; e.out_c = a;
				end else if ((e.new_count == 2'd1 && fresh[2]) ||
						(e.new_count == 2'd2 && !fresh[1])) begin
					e.out_a = c; e.out_b = a; e.out_c = b;
				end
			end else begin
				if (e.new_count == 2'd1) begin
					if (fresh[1]) begin
						e.out_a = b; e.out_b = a;
					end else if (fresh[2]) begin
						e.out_a = c; e.out_c = a;
					end
				end else if (e.new_count == 2'd2) begin
					if (!fresh[0]) begin
						e.out_a = c; e.out_c = a;
					end else if (!fresh[1]) begin
						e.out_b = c; e.out_c = b;
					end
				end
			end
			expected_q.push_back(e);
			if (last)
				clear_seen();
		endfunction

		task report(string what, int got, int want);
			errors++;
			if (errors <= PRINT_MAX)
				$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		endtask

		task check_result(logic [M_TDATA_W-1:0] data);
			out_item_t got;
			out_item_t want;
			got = out_item_t'(data[$bits(out_item_t)-1:0]);
			if (expected_q.size() == 0) begin
				report("unexpected item", int'(got.out_a), 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_a != want.out_a)
				report("out_a", got.out_a, want.out_a);
			if (got.out_b != want.out_b)
				report("out_b", got.out_b, want.out_b);
			if (got.out_c != want.out_c)
				report("out_c", got.out_c, want.out_c);
			if (got.new_count != want.new_count)
				report("new_count", got.new_count, want.new_count);
		endtask
	endclass

	triangle_scoreboard sb = new();

	first_owner_triangle_marker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_triangle(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// long hold-off is counted down here
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_triangle(idx_t a, idx_t b, idx_t c, logic last);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {c, b, a};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic set_order_mode(logic m);
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.mode = m;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one mesh hitting every reorder branch, ending on a fresh map
	task automatic directed_mesh();
		send_triangle(16'd1, 16'd2, 16'd3, 1'b0);
		send_triangle(16'd1, 16'd4, 16'd5, 1'b0);
		send_triangle(16'd6, 16'd1, 16'd7, 1'b0);
		send_triangle(16'd8, 16'd9, 16'd1, 1'b0);
		send_triangle(16'd10, 16'd1, 16'd2, 1'b0);
		send_triangle(16'd1, 16'd11, 16'd2, 1'b0);
		send_triangle(16'd1, 16'd2, 16'd12, 1'b0);
		send_triangle(16'd1, 16'd2, 16'd3, 1'b0);
		send_triangle(16'd20, 16'd20, 16'd20, 1'b0);
		send_triangle(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
		send_triangle(16'd1, 16'd2, 16'd3, 1'b1);
	endtask

	function automatic idx_t pick_index(idx_t base, int span);
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return base + idx_t'($urandom_range(span));
		else if (r < 92)
			return idx_t'($urandom_range(16'hFFFF));
		else
			return (r % 2) ? 16'hFFFF : 16'h0000;
	endfunction

	// meshes of clustered indices so that repeats are common
	task automatic random_meshes(int count);
		int   left;
		int   mesh_len;
		int   span;
		idx_t base;
		logic last;
		left = count;
		while (left > 0) begin
			mesh_len = $urandom_range(4, 40);
			if (mesh_len > left)
				mesh_len = left;
			base = idx_t'($urandom_range(16'hFFFF));
			span = $urandom_range(2, 48);
			for (int i = 0; i < mesh_len; i++) begin
				last = (i == mesh_len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 2);
				send_triangle(pick_index(base, span), pick_index(base, span),
						pick_index(base, span), last);
			end
			left -= mesh_len;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_order_mode(MODE_VERTEX);
		directed_mesh();
		wait_drained();
		set_order_mode(MODE_EDGE);
		directed_mesh();
		wait_drained();
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_pct_by_phase[ph];
			rx_stall_pct = rx_pct_by_phase[ph];
			set_order_mode((ph % 2) ? MODE_EDGE : MODE_VERTEX);
			if (ph == 0)
				rx_hold_cycles = 600;
			random_meshes(PHASE_ITEMS);
			wait_drained();
		end
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
